// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define LMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define LMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/lmf_pkg.sv
// ----------------------------------------------------------------------------
// lmf_pkg
// Widths, register codes and control structs of the label majority filter.
// ----------------------------------------------------------------------------
package lmf_pkg;

	// fixed field and register widths
	localparam int LABEL_W      = 5;
	localparam int WIDTH_REG_W  = 9;
	localparam int HEIGHT_REG_W = 13;
	localparam int RADIUS_REG_W = 2;
	localparam int COUNT_REG_W  = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int ROW_W        = 12;
	localparam int MAX_HEIGHT   = 4096;
	localparam int BEST_W       = 4;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_RADIUS_DEF = 2;
	localparam int MAX_LABELS_DEF = 16;

	// register reset values
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 9'd256;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd256;
	localparam logic [RADIUS_REG_W-1:0] RADIUS_RST = 2'd1;
	localparam logic [COUNT_REG_W-1:0]  COUNT_RST  = 5'd16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_COUNT  = 2'd3
	} cfg_reg_t;

	// sequencer to vote unit
	typedef struct packed {
		logic               clear;
		logic               inc;
		logic [LABEL_W-1:0] label;
		logic               pick;
	} vote_ctrl_t;

	// vote unit to sequencer
	typedef struct packed {
		logic              done;
		logic [BEST_W-1:0] best;
	} vote_stat_t;

endpackage

// File: rtl/core/lmf_store.sv
// ----------------------------------------------------------------------------
// lmf_store
// Line store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lmf_store #(
	parameter int DEPTH = 1280
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [lmf_pkg::LABEL_W-1:0]  wdata,
	input  logic                         re,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [lmf_pkg::LABEL_W-1:0]  rdata
);
	import lmf_pkg::*;

	logic [LABEL_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/lmf_vote.sv
// ----------------------------------------------------------------------------
// lmf_vote
// Per-label vote counters and a sequential search for the winning label.
// ----------------------------------------------------------------------------
module lmf_vote #(
	parameter int MAX_RADIUS = 2,
	parameter int MAX_LABELS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmf_pkg::vote_ctrl_t               ctrl,
	input  logic [lmf_pkg::COUNT_REG_W-1:0]   k,
	output lmf_pkg::vote_stat_t               stat
);
	import lmf_pkg::*;

	localparam int VOTE_N = (MAX_LABELS < 16) ? MAX_LABELS : 16;
	localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

	logic [CNT_W-1:0]       cnt_q [VOTE_N];
	logic [CNT_W-1:0]       sel_cnt;
	logic [CNT_W-1:0]       best_cnt_q;
	logic [BEST_W-1:0]      best_q;
	logic [COUNT_REG_W-1:0] c_q;
	logic                   picking_q;
	logic                   done_q;
	logic                   votes;

	// a label votes when not masked and below the label count
	assign votes = ctrl.inc && !ctrl.label[LABEL_W-1] && (ctrl.label < k);

	// counters
	always_ff @(posedge clk) begin
		for (int i = 0; i < VOTE_N; i++) begin
			if (ctrl.clear) begin
				cnt_q[i] <= '0;
			end else if (votes && (int'(ctrl.label) == i)) begin
				cnt_q[i] <= cnt_q[i] + 1'b1;
			end
		end
	end

	// count of the label under test
	always_comb begin
		sel_cnt = '0;
		for (int i = 0; i < VOTE_N; i++) begin
			if (int'(c_q) == i) begin
				sel_cnt = cnt_q[i];
			end
		end
	end

	// search: strictly greater wins, so ties keep the lowest label
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			picking_q  <= 1'b0;
			done_q     <= 1'b0;
			c_q        <= '0;
			best_q     <= '0;
			best_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.pick) begin
				picking_q  <= 1'b1;
				c_q        <= COUNT_REG_W'(1);
				best_q     <= '0;
				best_cnt_q <= cnt_q[0];
			end else if (picking_q) begin
				if (c_q >= k) begin
					picking_q <= 1'b0;
					done_q    <= 1'b1;
				end else begin
					if (sel_cnt > best_cnt_q) begin
						best_q     <= c_q[BEST_W-1:0];
						best_cnt_q <= sel_cnt;
					end
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.best = best_q;

endmodule

// File: rtl/core/label_majority_filter_unit.sv
// ----------------------------------------------------------------------------
// label_majority_filter_unit
// Streaming mode filter over a raster label map, window votes read from a
// circular line store.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  pixel   | pix_valid, pix_stall, kind, label_in      | in
//  result  | res_valid, res_stall, label_out, frame_end| out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  An item that releases no result passes through S_CHECK back to idle. One that
//  releases a masked centre goes through S_CHECK, S_CENTRE and S_OUT; otherwise
//  through S_CHECK, S_CENTRE, S_SCAN, S_FLUSH, S_START, S_PICK and S_OUT, paced
//  by the single read port of the line store (one window pixel a cycle) and the
//  one-label-a-cycle winner search, and held in S_OUT while the result is stalled.
//  Reset clears positions and loads the register reset values; the line store needs no clearing.
//  One item is in work at a time; pix_stall is high until it is finished and
//  while a register write is offered.
// ----------------------------------------------------------------------------
module label_majority_filter_unit #(
	parameter int MAX_WIDTH  = lmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = lmf_pkg::MAX_RADIUS_DEF,
	parameter int MAX_LABELS = lmf_pkg::MAX_LABELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic                              kind,
	input  logic signed [lmf_pkg::LABEL_W-1:0] label_in,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [lmf_pkg::LABEL_W-1:0] label_out,
	output logic                              frame_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lmf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lmf_pkg::*;

	localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int R_W    = $clog2(MAX_RADIUS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_CENTRE, S_SCAN, S_FLUSH, S_START, S_PICK, S_OUT
	} state_t;

	state_t state_q;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [RADIUS_REG_W-1:0] radius_q;
	logic [COUNT_REG_W-1:0]  count_q;

	logic [COL_W-1:0]  in_col_q, out_col_q, x_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q, y_q;
	logic [ADDR_W-1:0] wr_ptr_q, out_ptr_q, addr_q, row_q;
	logic              in_done_q;
	logic              scan_s1;
	logic [LABEL_W-1:0] result_q;

	logic [COL_W-1:0]       wm1, x0, x1;
	logic [COL_W:0]         w;
	logic [ROW_W-1:0]       hm1, y0, y1;
	logic [R_W-1:0]         r, dy, dx;
	logic [COUNT_REG_W-1:0] k;
	logic [COL_W:0]         xr_sum;
	logic [ROW_W:0]         yr_sum;
	logic [R_W+COL_W:0]     dyw;
	logic [ADDR_W+1:0]      base_raw;
	logic [ADDR_W-1:0]      base;
	logic                   ready_w, last_w;
	logic                   pix_acc, cfg_acc, res_acc, pix_write;

	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [LABEL_W-1:0] mem_rdata;
	vote_ctrl_t         vctrl;
	vote_stat_t         vstat;

	// circular address step
	function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
			input logic [COL_W:0] inc);
		logic [ADDR_W:0] s;
		s = (ADDR_W+1)'(a) + (ADDR_W+1)'(inc);
		if (s >= (ADDR_W+1)'(DEPTH)) begin
			s = s - (ADDR_W+1)'(DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	// effective register values
	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(int'(width_q) - 1);
		end
		if (height_q == '0) begin
			hm1 = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(int'(height_q) - 1);
		end
		r = (int'(radius_q) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_q);
		k = (int'(count_q) > MAX_LABELS) ? COUNT_REG_W'(MAX_LABELS) : count_q;
		w = {1'b0, wm1} + 1'b1;
	end

	// clipped window around the next result
	always_comb begin
		y0 = (out_row_q >= ROW_W'(r)) ? out_row_q - ROW_W'(r) : '0;
		x0 = (out_col_q >= COL_W'(r)) ? out_col_q - COL_W'(r) : '0;
		yr_sum = {1'b0, out_row_q} + (ROW_W+1)'(r);
		xr_sum = {1'b0, out_col_q} + (COL_W+1)'(r);
		y1 = (yr_sum > {1'b0, hm1}) ? hm1 : yr_sum[ROW_W-1:0];
		x1 = (xr_sum > {1'b0, wm1}) ? wm1 : xr_sum[COL_W-1:0];
		dy = R_W'(out_row_q - y0);
		dx = R_W'(out_col_q - x0);
		dyw = (R_W+COL_W+1)'(dy) * (R_W+COL_W+1)'(w);
		base_raw = (ADDR_W+2)'(out_ptr_q) - (ADDR_W+2)'(dyw) - (ADDR_W+2)'(dx);
		if (base_raw[ADDR_W+1]) begin
			base_raw = base_raw + (ADDR_W+2)'(DEPTH);
		end
		base = base_raw[ADDR_W-1:0];
	end

	// result ready once the window's last pixel has arrived
	assign ready_w = in_done_q || (in_row_q > y1) || ((in_row_q == y1) && (in_col_q > x1));
	assign last_w  = (out_row_q == hm1) && (out_col_q == wm1);

	// handshakes, a register write holds off pixel items
	assign pix_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign pix_acc   = pix_valid && !pix_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign res_acc   = res_valid && !res_stall;
	assign pix_write = pix_acc && !kind && !in_done_q && !cfg_acc;

	assign label_out = result_q;
	assign frame_end = last_w;

	// line store accesses
	assign mem_re    = (state_q == S_CHECK) || (state_q == S_SCAN);
	assign mem_raddr = (state_q == S_SCAN) ? addr_q : out_ptr_q;

	lmf_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (pix_write),
		.waddr (wr_ptr_q),
		.wdata (label_in),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// vote unit control
	always_comb begin
		vctrl.clear = (state_q == S_CENTRE);
		vctrl.inc   = scan_s1;
		vctrl.label = mem_rdata;
		vctrl.pick  = (state_q == S_START);
	end

	lmf_vote #(.MAX_RADIUS(MAX_RADIUS), .MAX_LABELS(MAX_LABELS)) u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (vctrl),
		.k      (k),
		.stat   (vstat)
	);

	// sequencer, positions and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			radius_q  <= RADIUS_RST;
			count_q   <= COUNT_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			in_done_q <= 1'b0;
			scan_s1   <= 1'b0;
			result_q  <= '0;
			x_q       <= '0;
			y_q       <= '0;
			addr_q    <= '0;
			row_q     <= '0;
		end else begin
			scan_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						case (cfg_index)
							REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
							REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
							REG_RADIUS: radius_q <= cfg_data[RADIUS_REG_W-1:0];
							REG_COUNT:  count_q  <= cfg_data[COUNT_REG_W-1:0];
							default:    width_q  <= width_q;
						endcase
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
						wr_ptr_q  <= '0;
						out_ptr_q <= '0;
						in_done_q <= 1'b0;
					end else if (pix_acc) begin
						if (pix_write) begin
							wr_ptr_q <= addr_add(wr_ptr_q, (COL_W+1)'(1));
							if (in_col_q == wm1) begin
								in_col_q <= '0;
								if (in_row_q == hm1) begin
									in_done_q <= 1'b1;
								end else begin
									in_row_q <= in_row_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= ready_w ? S_CENTRE : S_IDLE;
				end
				S_CENTRE: begin
					// masked centre passes through
					if (mem_rdata[LABEL_W-1]) begin
						result_q <= mem_rdata;
						state_q  <= S_OUT;
					end else begin
						y_q     <= y0;
						x_q     <= x0;
						addr_q  <= base;
						row_q   <= base;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (x_q == x1) begin
						if (y_q == y1) begin
							state_q <= S_FLUSH;
						end else begin
							y_q    <= y_q + 1'b1;
							x_q    <= x0;
							row_q  <= addr_add(row_q, w);
							addr_q <= addr_add(row_q, w);
						end
					end else begin
						x_q    <= x_q + 1'b1;
						addr_q <= addr_add(addr_q, (COL_W+1)'(1));
					end
				end
				S_FLUSH: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (vstat.done) begin
						result_q <= {1'b0, vstat.best};
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_acc) begin
						if (last_w) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							wr_ptr_q  <= '0;
							out_ptr_q <= '0;
							in_done_q <= 1'b0;
						end else begin
							out_ptr_q <= addr_add(out_ptr_q, (COL_W+1)'(1));
							if (out_col_q == wm1) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + 1'b1;
							end else begin
								out_col_q <= out_col_q + 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/lmf_checker.sv
// ----------------------------------------------------------------------------
// lmf_checker
// Port-level checks of the label majority filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              pix_valid,
	input logic                              pix_stall,
	input logic                              kind,
	input logic signed [lmf_pkg::LABEL_W-1:0] label_in,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic signed [lmf_pkg::LABEL_W-1:0] label_out,
	input logic                              frame_end,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [lmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [lmf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lmf_pkg::*;

	// a stalled result holds
	`LMF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(label_out) && $stable(frame_end))

	// the block is busy in the cycle after it takes an item
	`LMF_ASSERT_NEXT(a_busy_after_item, clk, arst_n, pix_valid && !pix_stall, pix_stall)

	// no item is taken while a result waits
	`LMF_ASSERT_NOW(a_no_item_with_result, clk, arst_n, res_valid, pix_stall)

	// configuration is taken only when nothing is in work, and holds off items
	`LMF_ASSERT_NOW(a_cfg_when_idle, clk, arst_n, cfg_valid && cfg_ready, pix_stall && !res_valid)

endmodule

bind label_majority_filter_unit lmf_checker u_lmf_checker (.*);
